FILE: hdl/rotation_matrix_to_quaternion_defines.svh
// Assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Check a consequent in the same cycle as the antecedent
`define RMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent one full pipeline latency after the antecedent
`define RMQ_ASSERT_LAT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##LATENCY (cons)) else $error(msg);

`endif

FILE: hdl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    localparam int DATA_W    = 16;
    localparam int LANES     = 4;
    localparam int Q_W       = 18;
    localparam int N2_W      = 36;
    localparam int QT_W      = 31;
    localparam int RT_W      = 32;
    localparam int SQ_STAGES = 16;
    localparam int ROOT_W    = 16;
    localparam int FRONT_STAGES = 4;
    localparam int LATENCY   = FRONT_STAGES + QT_W + SQ_STAGES + 1;

    localparam logic signed [Q_W-1:0] QONE_Q = 18'sd16384;

    typedef enum logic [1:0] {
        CASE_W = 2'd0,
        CASE_X = 2'd1,
        CASE_Y = 2'd2,
        CASE_Z = 2'd3
    } t_case;

    typedef logic signed [Q_W-1:0] t_q;

    typedef struct packed {
        logic             vld;
        logic [LANES-1:0] neg;
    } t_ctrl;

    typedef logic [LANES-1:0][N2_W-1:0]   t_mag2_vec;
    typedef logic [LANES-1:0][ROOT_W-1:0] t_root_vec;

endpackage

`default_nettype wire

FILE: hdl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, fully pipelined
// Throughput: one transaction per cycle; busy stays low, results cannot be held off.
// Depth is set by the 31-stage restoring divider and the 16-stage square root.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c0_r0,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c0_r1,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c0_r2,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c1_r0,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c1_r1,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c1_r2,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c2_r0,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c2_r1,
    input  logic signed [rmq_pkg::DATA_W-1:0]   i_c2_r2,
    output logic                                o_valid,
    output logic signed [rmq_pkg::DATA_W-1:0]   o_quat_w,
    output logic signed [rmq_pkg::DATA_W-1:0]   o_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0]   o_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0]   o_quat_z
);
    import rmq_pkg::*;

    t_q w_m00, w_m01, w_m02, w_m10, w_m11, w_m12, w_m20, w_m21, w_m22;
    logic w_accept;

    logic r1_vld;
    t_q   r1_t [LANES];
    t_q   r1_d12, r1_s12, r1_d20, r1_s20, r1_d01, r1_s01;

    t_case w_best;
    t_q    w_q [LANES];

    logic r2_vld;
    t_q   r2_q [LANES];

    logic signed [2*Q_W-1:0] w_sq [LANES];

    logic             r3_vld;
    logic [LANES-1:0] r3_neg;
    t_mag2_vec        r3_mag2;

    logic [N2_W+1:0]  w_n2_sum;

    logic             r4_vld;
    logic [LANES-1:0] r4_neg;
    t_mag2_vec        r4_mag2;
    logic [N2_W-1:0]  r4_n2;

    t_ctrl     w_nctrl_in;
    t_ctrl     w_nctrl_out;
    t_root_vec w_root;

    logic [LANES-1:0][DATA_W-1:0] w_mag;
    logic                         r_ovld;
    logic [LANES-1:0][DATA_W-1:0] r_quat;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_m00 = t_q'(i_c0_r0);
    assign w_m01 = t_q'(i_c0_r1);
    assign w_m02 = t_q'(i_c0_r2);
    assign w_m10 = t_q'(i_c1_r0);
    assign w_m11 = t_q'(i_c1_r1);
    assign w_m12 = t_q'(i_c1_r2);
    assign w_m20 = t_q'(i_c2_r0);
    assign w_m21 = t_q'(i_c2_r1);
    assign w_m22 = t_q'(i_c2_r2);

    // stage 1: traces and off-diagonal terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t[CASE_W] <= QONE_Q + w_m00 + w_m11 + w_m22;
        r1_t[CASE_X] <= QONE_Q + w_m00 - w_m11 - w_m22;
        r1_t[CASE_Y] <= QONE_Q - w_m00 + w_m11 - w_m22;
        r1_t[CASE_Z] <= QONE_Q - w_m00 - w_m11 + w_m22;
        r1_d12 <= w_m12 - w_m21;
        r1_s12 <= w_m12 + w_m21;
        r1_d20 <= w_m20 - w_m02;
        r1_s20 <= w_m20 + w_m02;
        r1_d01 <= w_m01 - w_m10;
        r1_s01 <= w_m01 + w_m10;
    end

    // stage 2: pick largest trace, lowest index on ties
    always_comb begin
        w_best = CASE_W;
        if (r1_t[CASE_X] > r1_t[w_best]) begin
            w_best = CASE_X;
        end
        if (r1_t[CASE_Y] > r1_t[w_best]) begin
            w_best = CASE_Y;
        end
        if (r1_t[CASE_Z] > r1_t[w_best]) begin
            w_best = CASE_Z;
        end
    end

    always_comb begin
        case (w_best)
            CASE_X: begin
                w_q[0] = r1_d12;
                w_q[1] = r1_t[CASE_X];
                w_q[2] = r1_s01;
                w_q[3] = r1_s20;
            end
            CASE_Y: begin
                w_q[0] = r1_d20;
                w_q[1] = r1_s01;
                w_q[2] = r1_t[CASE_Y];
                w_q[3] = r1_s12;
            end
            CASE_Z: begin
                w_q[0] = r1_d01;
                w_q[1] = r1_s20;
                w_q[2] = r1_s12;
                w_q[3] = r1_t[CASE_Z];
            end
            default: begin
                w_q[0] = r1_t[CASE_W];
                w_q[1] = r1_d12;
                w_q[2] = r1_d20;
                w_q[3] = r1_d01;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r2_q[l] <= w_q[l];
        end
    end

    // stage 3: squares
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_sq[l] = r2_q[l] * r2_q[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r3_mag2[l] <= N2_W'(w_sq[l]);
            r3_neg[l]  <= r2_q[l][Q_W-1];
        end
    end

    // stage 4: squared norm
    assign w_n2_sum = (N2_W+2)'(r3_mag2[0]) + (N2_W+2)'(r3_mag2[1])
                    + (N2_W+2)'(r3_mag2[2]) + (N2_W+2)'(r3_mag2[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_n2   <= w_n2_sum[N2_W-1:0];
        r4_mag2 <= r3_mag2;
        r4_neg  <= r3_neg;
    end

    assign w_nctrl_in.vld = r4_vld;
    assign w_nctrl_in.neg = r4_neg;

    rmq_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_nctrl_in),
        .i_mag2  (r4_mag2),
        .i_n2    (r4_n2),
        .o_ctrl  (w_nctrl_out),
        .o_root  (w_root)
    );

    // round to nearest odd bound and restore sign
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_mag[l] = (w_root[l] + ROOT_W'(1)) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= w_nctrl_out.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (w_nctrl_out.neg[l]) begin
                r_quat[l] <= ~w_mag[l] + DATA_W'(1);
            end else begin
                r_quat[l] <= w_mag[l];
            end
        end
    end

    assign o_valid  = r_ovld;
    assign o_quat_w = r_quat[0];
    assign o_quat_x = r_quat[1];
    assign o_quat_y = r_quat[2];
    assign o_quat_z = r_quat[3];

    `RMQ_ASSERT_LAT(a_accept_gives_result, w_accept, o_valid, "transaction lost in pipeline")
    `RMQ_ASSERT_LAT(a_idle_gives_none, !w_accept, !o_valid, "result without transaction")
    `RMQ_ASSERT_NOW(a_result_nonzero, o_valid, (o_quat_w != 0) || (o_quat_x != 0) || (o_quat_y != 0) || (o_quat_z != 0), "all quaternion parts zero")
    `RMQ_ASSERT_NOW(a_result_range, o_valid, (o_quat_w >= -16'sd16384) && (o_quat_w <= 16'sd16384) && (o_quat_x >= -16'sd16384) && (o_quat_x <= 16'sd16384) && (o_quat_y >= -16'sd16384) && (o_quat_y <= 16'sd16384) && (o_quat_z >= -16'sd16384) && (o_quat_z <= 16'sd16384), "quaternion part beyond unit")

endmodule

`default_nettype wire

FILE: hdl/rmq_norm.sv
// Pipelined ratio divider and integer square root for the four quaternion parts
`timescale 1ns / 1ps
`default_nettype none

module rmq_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rmq_pkg::t_ctrl               i_ctrl,
    input  rmq_pkg::t_mag2_vec           i_mag2,
    input  logic [rmq_pkg::N2_W-1:0]     i_n2,
    output rmq_pkg::t_ctrl               o_ctrl,
    output rmq_pkg::t_root_vec           o_root
);
    import rmq_pkg::*;

    logic             r_dvld [QT_W];
    logic [LANES-1:0] r_dneg [QT_W];
    logic [N2_W-1:0]  r_dn2  [QT_W-1];
    logic [N2_W-1:0]  r_rem  [QT_W-1][LANES];
    logic [QT_W-1:0]  r_quo  [QT_W][LANES];

    logic             r_svld  [SQ_STAGES];
    logic [LANES-1:0] r_sneg  [SQ_STAGES];
    logic [RT_W-1:0]  r_srem  [SQ_STAGES-1][LANES];
    logic [RT_W-1:0]  r_sroot [SQ_STAGES][LANES];

    genvar gi, gl, gj;

    // quotient floor(mag2 * 2^30 / n2), one bit per stage
    for (gi = 0; gi < QT_W; gi++) begin : g_div
        logic                          w_vld;
        logic [LANES-1:0]              w_neg;
        logic [N2_W-1:0]               w_n2;
        logic [LANES-1:0][N2_W:0]      w_trial;
        logic [LANES-1:0][QT_W-1:0]    w_quo;
        logic [LANES-1:0]              w_ge;
        logic [LANES-1:0][N2_W:0]      w_diff;

        if (gi == 0) begin : g_src
            assign w_vld = i_ctrl.vld;
            assign w_neg = i_ctrl.neg;
            assign w_n2  = i_n2;
            for (gl = 0; gl < LANES; gl++) begin : g_l
                assign w_trial[gl] = {1'b0, i_mag2[gl]};
                assign w_quo[gl]   = '0;
            end
        end else begin : g_src
            assign w_vld = r_dvld[gi-1];
            assign w_neg = r_dneg[gi-1];
            assign w_n2  = r_dn2[gi-1];
            for (gl = 0; gl < LANES; gl++) begin : g_l
                assign w_trial[gl] = {r_rem[gi-1][gl], 1'b0};
                assign w_quo[gl]   = r_quo[gi-1][gl];
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_ge[l]   = (w_trial[l] >= {1'b0, w_n2});
                w_diff[l] = w_trial[l] - {1'b0, w_n2};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[gi] <= 1'b0;
            end else begin
                r_dvld[gi] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dneg[gi] <= w_neg;
            for (int l = 0; l < LANES; l++) begin
                r_quo[gi][l] <= {w_quo[l][QT_W-2:0], w_ge[l]};
            end
        end

        if (gi < QT_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_dn2[gi] <= w_n2;
                for (int l = 0; l < LANES; l++) begin
                    if (w_ge[l]) begin
                        r_rem[gi][l] <= w_diff[l][N2_W-1:0];
                    end else begin
                        r_rem[gi][l] <= w_trial[l][N2_W-1:0];
                    end
                end
            end
        end
    end

    // integer square root of the quotient, one result bit per stage
    for (gj = 0; gj < SQ_STAGES; gj++) begin : g_sqrt
        localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQ_STAGES - 1 - gj));

        logic                       w_vld;
        logic [LANES-1:0]           w_neg;
        logic [LANES-1:0][RT_W-1:0] w_rem;
        logic [LANES-1:0][RT_W-1:0] w_root;
        logic [LANES-1:0][RT_W-1:0] w_sum;
        logic [LANES-1:0]           w_ge;

        if (gj == 0) begin : g_src
            assign w_vld = r_dvld[QT_W-1];
            assign w_neg = r_dneg[QT_W-1];
            for (gl = 0; gl < LANES; gl++) begin : g_l
                assign w_rem[gl]  = RT_W'(r_quo[QT_W-1][gl]);
                assign w_root[gl] = '0;
            end
        end else begin : g_src
            assign w_vld = r_svld[gj-1];
            assign w_neg = r_sneg[gj-1];
            for (gl = 0; gl < LANES; gl++) begin : g_l
                assign w_rem[gl]  = r_srem[gj-1][gl];
                assign w_root[gl] = r_sroot[gj-1][gl];
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_sum[l] = w_root[l] + BIT;
                w_ge[l]  = (w_rem[l] >= w_sum[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[gj] <= 1'b0;
            end else begin
                r_svld[gj] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sneg[gj] <= w_neg;
            for (int l = 0; l < LANES; l++) begin
                if (w_ge[l]) begin
                    r_sroot[gj][l] <= (w_root[l] >> 1) + BIT;
                end else begin
                    r_sroot[gj][l] <= w_root[l] >> 1;
                end
            end
        end

        if (gj < SQ_STAGES - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                for (int l = 0; l < LANES; l++) begin
                    if (w_ge[l]) begin
                        r_srem[gj][l] <= w_rem[l] - w_sum[l];
                    end else begin
                        r_srem[gj][l] <= w_rem[l];
                    end
                end
            end
        end
    end

    assign o_ctrl.vld = r_svld[SQ_STAGES-1];
    assign o_ctrl.neg = r_sneg[SQ_STAGES-1];

    for (gl = 0; gl < LANES; gl++) begin : g_out
        assign o_root[gl] = r_sroot[SQ_STAGES-1][gl][ROOT_W-1:0];
    end

endmodule

`default_nettype wire

FILE: bench/quaternion_checker.sv
// Checker: predicts the unit quaternion of each accepted matrix and compares results
`timescale 1ns / 1ps

module quaternion_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] i_m [9],
    input  logic        o_valid,
    input  logic [15:0] o_quat_w,
    input  logic [15:0] o_quat_x,
    input  logic [15:0] o_quat_y,
    input  logic [15:0] o_quat_z,
    output int          o_fail_count,
    output int          o_pending
);
    import rmq_pkg::*;

    typedef struct {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_quat;

    t_quat expected_quats[$];

    function automatic logic [15:0] round_norm(longint q, longint n2);
        logic [127:0] lhs;
        logic [127:0] rhs;
        longint mag;
        longint lo;
        longint hi;
        longint mid;
        longint d;
        mag = (q < 0) ? -q : q;
        lo = 0;
        hi = 16384;
        rhs = 128'(mag) * 128'(mag);
        rhs = rhs << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 2 * mid - 1;
            lhs = 128'(d) * 128'(d) * 128'(n2);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (q < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic t_quat shepperd_quat(logic [15:0] m [9]);
        longint v [9];
        longint t [4];
        longint q [4];
        longint n2;
        t_case pick;
        t_quat r;
        for (int k = 0; k < 9; k++) v[k] = longint'($signed(m[k]));
        // v index: 3*column + row
        t[0] = 16384 + v[0] + v[4] + v[8];
        t[1] = 16384 + v[0] - v[4] - v[8];
        t[2] = 16384 - v[0] + v[4] - v[8];
        t[3] = 16384 - v[0] - v[4] + v[8];
        pick = CASE_W;
        if (t[1] > t[pick]) pick = CASE_X;
        if (t[2] > t[pick]) pick = CASE_Y;
        if (t[3] > t[pick]) pick = CASE_Z;
        case (pick)
            CASE_W: begin
                q[0] = t[0];        q[1] = v[5] - v[7];
                q[2] = v[6] - v[2]; q[3] = v[1] - v[3];
            end
            CASE_X: begin
                q[0] = v[5] - v[7]; q[1] = t[1];
                q[2] = v[1] + v[3]; q[3] = v[6] + v[2];
            end
            CASE_Y: begin
                q[0] = v[6] - v[2]; q[1] = v[1] + v[3];
                q[2] = t[2];        q[3] = v[5] + v[7];
            end
            default: begin
                q[0] = v[1] - v[3]; q[1] = v[6] + v[2];
                q[2] = v[5] + v[7]; q[3] = t[3];
            end
        endcase
        n2 = 0;
        for (int k = 0; k < 4; k++) n2 += q[k] * q[k];
        r.w = round_norm(q[0], n2);
        r.x = round_norm(q[1], n2);
        r.y = round_norm(q[2], n2);
        r.z = round_norm(q[3], n2);
        return r;
    endfunction

    assign o_pending = expected_quats.size();

    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n) begin
            if (start && !busy) expected_quats.push_back(shepperd_quat(i_m));
            if (o_valid) begin
                if (expected_quats.size() == 0) begin
                    $error("unexpected result w=%0d x=%0d y=%0d z=%0d",
                        $signed(o_quat_w), $signed(o_quat_x),
                        $signed(o_quat_y), $signed(o_quat_z));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_q = expected_quats.pop_front();
                    if (exp_q.w !== o_quat_w || exp_q.x !== o_quat_x ||
                        exp_q.y !== o_quat_y || exp_q.z !== o_quat_z) begin
                        o_fail_count <= o_fail_count + 1;
                        if (exp_q.w !== o_quat_w)
                            $error("quat_w expected %0d actual %0d",
                                $signed(exp_q.w), $signed(o_quat_w));
                        if (exp_q.x !== o_quat_x)
                            $error("quat_x expected %0d actual %0d",
                                $signed(exp_q.x), $signed(o_quat_x));
                        if (exp_q.y !== o_quat_y)
                            $error("quat_y expected %0d actual %0d",
                                $signed(exp_q.y), $signed(o_quat_y));
                        if (exp_q.z !== o_quat_z)
                            $error("quat_z expected %0d actual %0d",
                                $signed(exp_q.z), $signed(o_quat_z));
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb_rotation_matrix_to_quaternion.sv
// Testbench top: drives matrices into the quaternion block and reports the verdict
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int DRAIN_CYCLES = LATENCY + 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] mat [9];
    logic        o_valid;
    logic [15:0] o_quat_w;
    logic [15:0] o_quat_x;
    logic [15:0] o_quat_y;
    logic [15:0] o_quat_z;
    int          fail_count;
    int          pending;
    int          idle_pct;

    rotation_matrix_to_quaternion u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_c0_r0 (mat[0]),
        .i_c0_r1 (mat[1]),
        .i_c0_r2 (mat[2]),
        .i_c1_r0 (mat[3]),
        .i_c1_r1 (mat[4]),
        .i_c1_r2 (mat[5]),
        .i_c2_r0 (mat[6]),
        .i_c2_r1 (mat[7]),
        .i_c2_r2 (mat[8]),
        .o_valid (o_valid),
        .o_quat_w(o_quat_w),
        .o_quat_x(o_quat_x),
        .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z)
    );

    quaternion_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_m         (mat),
        .o_valid     (o_valid),
        .o_quat_w    (o_quat_w),
        .o_quat_x    (o_quat_x),
        .o_quat_y    (o_quat_y),
        .o_quat_z    (o_quat_z),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_matrix(input logic [15:0] m [9]);
        start <= 1'b1;
        for (int k = 0; k < 9; k++) mat[k] <= m[k];
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_fill(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] m [9];
        for (int k = 0; k < 9; k++) m[k] = (k % 2) ? b : a;
        send_matrix(m);
    endtask

    task automatic send_diag(input int d0, input int d1, input int d2, input int off);
        logic [15:0] m [9];
        for (int k = 0; k < 9; k++) m[k] = 16'(off);
        m[0] = 16'(d0);
        m[4] = 16'(d1);
        m[8] = 16'(d2);
        send_matrix(m);
    endtask

    task automatic send_rotation();
        logic [15:0] m [9];
        real a, b, c, d, n, s;
        real r [9];
        a = real'($signed($urandom_range(2000))) - 1000.0;
        b = real'($signed($urandom_range(2000))) - 1000.0;
        c = real'($signed($urandom_range(2000))) - 1000.0;
        d = real'($signed($urandom_range(2000))) - 1000.0;
        n = a * a + b * b + c * c + d * d + 1.0;
        s = 2.0 / n;
        r[0] = 1.0 - s * (c * c + d * d);
        r[4] = 1.0 - s * (b * b + d * d);
        r[8] = 1.0 - s * (b * b + c * c);
        r[1] = s * (b * c + a * d);
        r[3] = s * (b * c - a * d);
        r[2] = s * (b * d - a * c);
        r[6] = s * (b * d + a * c);
        r[5] = s * (c * d + a * b);
        r[7] = s * (c * d - a * b);
        for (int k = 0; k < 9; k++)
            m[k] = 16'($rtoi(r[k] * 16384.0) + $signed($urandom_range(6)) - 3);
        send_matrix(m);
    endtask

    task automatic send_noise();
        logic [15:0] m [9];
        for (int k = 0; k < 9; k++) m[k] = 16'($urandom);
        send_matrix(m);
    endtask

    initial begin
        start = 1'b0;
        for (int k = 0; k < 9; k++) mat[k] = '0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fill(16'h0000, 16'h0000);
        send_fill(16'h7FFF, 16'h7FFF);
        send_fill(16'h8000, 16'h8000);
        send_fill(16'h5555, 16'hAAAA);
        send_fill(16'hAAAA, 16'h5555);
        send_fill(16'h7FFF, 16'h8000);
        send_fill(16'hFFFF, 16'h0001);
        send_diag(16384, 16384, 16384, 0);
        send_diag(16384, -16384, -16384, 0);
        send_diag(-16384, 16384, -16384, 0);
        send_diag(-16384, -16384, 16384, 0);
        send_diag(0, 0, 0, 0);
        send_diag(8192, 8192, -8192, 1234);
        send_diag(-16384, -16384, -16384, 0);
        send_diag(32767, -32768, 32767, -32768);
        send_diag(-32768, 32767, -32768, 32767);
        send_diag(-32768, -32768, 32767, 100);
        send_diag(100, 100, 100, -32768);
        send_diag(0, 0, 16384, 16384);

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 56;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            for (int i = 0; i < 500; i++) begin
                if ($urandom_range(99) < 70) send_rotation();
                else send_noise();
            end
            start <= 1'b0;
            while (pending != 0) @(posedge i_clk);
            @(posedge i_clk);
        end

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
